### rtl/mhpq_pkg.sv
//------------------------------------------------------------------------------
// mhpq_pkg
// Shared codes and controller/datapath interface types for the max-heap queue.
//------------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

    typedef logic [1:0] op_t;
    typedef logic [1:0] status_t;

    localparam op_t OP_INSERT  = 2'd0;
    localparam op_t OP_EXTRACT = 2'd1;
    localparam op_t OP_PEEK    = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic    ins_start;   // latch new entry, bump count, read parent
        logic    top_start;   // read root and last entry
        logic    pop;         // with top_start: drop count by one
        logic    take_top;    // capture root as result, last as moving entry
        logic    up_step;     // one sift-up level
        logic    dn_step;     // one sift-down level
        logic    put;         // write moving entry at current slot
        logic    clear_res;   // result fields zero, status from res_status
        status_t res_status;
        logic    load_out;    // move result into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic up_less;     // parent strictly below moving entry
        logic up_root;     // parent is the root slot
        logic dn_move;     // a child strictly above moving entry
        logic dn_child;    // new slot still has a left child
        logic take_child;  // root has a left child after the pop
    } sts_t;

endpackage

`default_nettype wire

### rtl/mhpq_ctrl.sv
//------------------------------------------------------------------------------
// mhpq_ctrl
// Operation sequencer: decodes the request, walks the sift, hands off result.
//------------------------------------------------------------------------------
`default_nettype none

module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire op_t  s_operation,
    output logic      m_valid,
    input  wire logic m_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_UP     = 6'b000010,
        S_FETCH  = 6'b000100,
        S_DN     = 6'b001000,
        S_PUT    = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   pop_reg, pop_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        pop_next     = pop_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.res_status = ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_operation)
                        OP_INSERT: begin
                            cmd.clear_res = 1'b1;
                            if (sts.full) begin
                                cmd.res_status = ST_FULL;
                                state_next     = S_FINISH;
                            end else begin
                                cmd.ins_start = 1'b1;
                                state_next    = sts.empty ? S_PUT : S_UP;
                            end
                        end
                        OP_EXTRACT, OP_PEEK: begin
                            if (sts.empty) begin
                                cmd.clear_res  = 1'b1;
                                cmd.res_status = ST_EMPTY;
                                state_next     = S_FINISH;
                            end else begin
                                cmd.top_start = 1'b1;
                                cmd.pop       = (s_operation == OP_EXTRACT);
                                pop_next      = (s_operation == OP_EXTRACT);
                                state_next    = S_FETCH;
                            end
                        end
                        default: begin
                            // reserved code: no-op transaction
                            cmd.clear_res = 1'b1;
                            state_next    = S_FINISH;
                        end
                    endcase
                end
            end
            S_UP: begin
                cmd.up_step = 1'b1;
                if (!sts.up_less) begin
                    state_next = S_FINISH;
                end else if (sts.up_root) begin
                    state_next = S_PUT;
                end
            end
            S_FETCH: begin
                cmd.take_top = 1'b1;
                if (!pop_reg || sts.empty) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = sts.take_child ? S_DN : S_PUT;
                end
            end
            S_DN: begin
                cmd.dn_step = 1'b1;
                if (!sts.dn_move) begin
                    state_next = S_FINISH;
                end else if (!sts.dn_child) begin
                    state_next = S_PUT;
                end
            end
            S_PUT: begin
                cmd.put    = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pop_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pop_reg     <= pop_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/mhpq_dp.sv
//------------------------------------------------------------------------------
// mhpq_dp
// Heap storage (1 write, 2 registered reads), sift registers and result path.
//------------------------------------------------------------------------------
`default_nettype none

module mhpq_dp
    import mhpq_pkg::*;
#(
    parameter int CAPACITY      = 64,
    parameter int PRIORITY_BITS = 16,
    parameter int TAG_BITS      = 16,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic [PRIORITY_BITS-1:0] s_priority_req,
    input  wire logic [TAG_BITS-1:0]      s_task_tag,
    input  wire cmd_t                     cmd,
    output sts_t                          sts,
    output logic [PRIORITY_BITS-1:0]      m_out_priority,
    output logic [TAG_BITS-1:0]           m_out_tag,
    output status_t                       m_status,
    output logic                          m_now_empty,
    output logic [CW-1:0]                 m_entry_count
);

    localparam int IW = $clog2(CAPACITY);
    localparam int XW = IW + 2;
    localparam int EW = PRIORITY_BITS + TAG_BITS;
    localparam logic [XW-1:0] ONE_X = XW'(1);
    localparam logic [XW-1:0] TWO_X = XW'(2);
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    logic [EW-1:0] mem [CAPACITY];
    logic [EW-1:0] rd_a_reg, rd_b_reg;

    logic [CW-1:0]            count_reg, count_next;
    logic [IW-1:0]            i_reg, i_next;
    logic [PRIORITY_BITS-1:0] x_pri_reg, x_pri_next;
    logic [TAG_BITS-1:0]      x_tag_reg, x_tag_next;
    logic [PRIORITY_BITS-1:0] res_pri_reg, res_pri_next;
    logic [TAG_BITS-1:0]      res_tag_reg, res_tag_next;
    status_t                  res_status_reg, res_status_next;

    logic [PRIORITY_BITS-1:0] a_pri, b_pri, best_pri;
    logic [XW-1:0] cnt_x, i_x, last_x, ins_par_x, up_p_x, up_pp_x;
    logic [XW-1:0] l_x, r_x, next_x, nl_x, nr_x;
    logic          up_less, pick_l, pick_r;
    logic          we;
    logic [IW-1:0] wa, ra_a, ra_b;
    logic [EW-1:0] wd;

    assign a_pri = rd_a_reg[EW-1 -: PRIORITY_BITS];
    assign b_pri = rd_b_reg[EW-1 -: PRIORITY_BITS];

    // heap index arithmetic, two bits of headroom over the slot index
    assign cnt_x     = XW'(count_reg);
    assign i_x       = XW'(i_reg);
    assign last_x    = cnt_x - ONE_X;
    assign ins_par_x = (cnt_x - ONE_X) >> 1;
    assign up_p_x    = (i_x - ONE_X) >> 1;
    assign up_pp_x   = (up_p_x - ONE_X) >> 1;
    assign l_x       = (i_x << 1) + ONE_X;
    assign r_x       = (i_x << 1) + TWO_X;

    assign up_less  = $signed(a_pri) < $signed(x_pri_reg);
    // left child is known present in the compare state; ties stay left
    assign pick_l   = $signed(a_pri) > $signed(x_pri_reg);
    assign best_pri = pick_l ? a_pri : x_pri_reg;
    assign pick_r   = (r_x < cnt_x) && ($signed(b_pri) > $signed(best_pri));
    assign next_x   = pick_r ? r_x : l_x;
    assign nl_x     = (next_x << 1) + ONE_X;
    assign nr_x     = (next_x << 1) + TWO_X;

    assign sts.empty      = (count_reg == '0);
    assign sts.full       = (cnt_x >= CAP_X);
    assign sts.up_less    = up_less;
    assign sts.up_root    = (up_p_x == '0);
    assign sts.dn_move    = pick_l || pick_r;
    assign sts.dn_child   = (nl_x < cnt_x);
    assign sts.take_child = (ONE_X < cnt_x);

    // memory port steering
    always_comb begin
        we   = 1'b0;
        wa   = i_reg;
        wd   = {x_pri_reg, x_tag_reg};
        ra_a = ins_par_x[IW-1:0];
        ra_b = last_x[IW-1:0];
        priority if (cmd.top_start) begin
            ra_a = '0;
        end else if (cmd.take_top) begin
            ra_a = ONE_X[IW-1:0];
            ra_b = TWO_X[IW-1:0];
        end else if (cmd.up_step) begin
            we   = 1'b1;
            ra_a = up_pp_x[IW-1:0];
            if (up_less) begin
                wd = rd_a_reg;
            end
        end else if (cmd.dn_step) begin
            we   = 1'b1;
            ra_a = nl_x[IW-1:0];
            ra_b = nr_x[IW-1:0];
            if (pick_r) begin
                wd = rd_b_reg;
            end else if (pick_l) begin
                wd = rd_a_reg;
            end
        end else if (cmd.put) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_a_reg <= mem[ra_a];
        rd_b_reg <= mem[ra_b];
    end

    always_comb begin
        count_next      = count_reg;
        i_next          = i_reg;
        x_pri_next      = x_pri_reg;
        x_tag_next      = x_tag_reg;
        res_pri_next    = res_pri_reg;
        res_tag_next    = res_tag_reg;
        res_status_next = res_status_reg;
        if (cmd.clear_res) begin
            res_pri_next    = '0;
            res_tag_next    = '0;
            res_status_next = cmd.res_status;
        end
        if (cmd.ins_start) begin
            count_next = count_reg + CW'(1);
            i_next     = count_reg[IW-1:0];
            x_pri_next = s_priority_req;
            x_tag_next = s_task_tag;
        end
        if (cmd.top_start && cmd.pop) begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.take_top) begin
            res_pri_next    = a_pri;
            res_tag_next    = rd_a_reg[TAG_BITS-1:0];
            res_status_next = ST_OK;
            x_pri_next      = b_pri;
            x_tag_next      = rd_b_reg[TAG_BITS-1:0];
            i_next          = '0;
        end
        if (cmd.up_step && up_less) begin
            i_next = up_p_x[IW-1:0];
        end
        if (cmd.dn_step && (pick_l || pick_r)) begin
            i_next = next_x[IW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg          <= i_next;
        x_pri_reg      <= x_pri_next;
        x_tag_reg      <= x_tag_next;
        res_pri_reg    <= res_pri_next;
        res_tag_reg    <= res_tag_next;
        res_status_reg <= res_status_next;
        if (cmd.load_out) begin
            m_out_priority <= res_pri_reg;
            m_out_tag      <= res_tag_reg;
            m_status       <= res_status_reg;
            m_now_empty    <= (count_reg == '0);
            m_entry_count  <= count_reg;
        end
    end

endmodule

`default_nettype wire

### rtl/max_heap_priority_queue.sv
//------------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap priority queue: insert, extract maximum, peek maximum.
//------------------------------------------------------------------------------
// One operation in flight; the sift moves one heap level per cycle through the
// two-read-port entry memory, and the next request is taken once the result is
// registered, which waits for m_ready while an earlier result is still pending.
// Reset empties the queue (fill count zero); entry memory is not cleared.
//------------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY      = 64,
    parameter int PRIORITY_BITS = 16,
    parameter int TAG_BITS      = 16,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_operation,
    input  wire logic [PRIORITY_BITS-1:0] s_priority_req,
    input  wire logic [TAG_BITS-1:0]      s_task_tag,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [PRIORITY_BITS-1:0]      m_out_priority,
    output logic [TAG_BITS-1:0]           m_out_tag,
    output logic [1:0]                    m_status,
    output logic                          m_now_empty,
    output logic [CW-1:0]                 m_entry_count
);

    cmd_t cmd;
    sts_t sts;

    mhpq_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .sts         (sts),
        .cmd         (cmd)
    );

    mhpq_dp #(
        .CAPACITY      (CAPACITY),
        .PRIORITY_BITS (PRIORITY_BITS),
        .TAG_BITS      (TAG_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_priority_req (s_priority_req),
        .s_task_tag     (s_task_tag),
        .cmd            (cmd),
        .sts            (sts),
        .m_out_priority (m_out_priority),
        .m_out_tag      (m_out_tag),
        .m_status       (m_status),
        .m_now_empty    (m_now_empty),
        .m_entry_count  (m_entry_count)
    );

    // a transaction always takes the sequencer out of idle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one in progress");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entry_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_entry_count == CW'(CAPACITY))
        else $error("full status with queue not full");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_now_empty == (m_entry_count == '0))
        else $error("empty flag disagrees with count");

    a_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_now_empty)
        else $error("underflow reported on non-empty queue");

endmodule

`default_nettype wire
